// ===== hdl/mftt_pkg.sv =====
// Package for the motor feedback turn tracker.
// Holds the encoder count constants, the item and state types and the
// position reduction function. No dependencies.
package mftt_pkg;

    localparam int unsigned ENCODER_COUNTS = 65536;
    localparam int unsigned HALF_COUNTS    = ENCODER_COUNTS / 2;

    localparam int POS_W   = 16;
    localparam int SUM_W   = POS_W + 1;
    localparam int ANGLE_W = 17;
    localparam int TURNS_W = 32;
    localparam int TOTAL_W = 48;
    localparam int CMP_W   = POS_W + 2;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam bit IS_POW2 = ((ENCODER_COUNTS & (ENCODER_COUNTS - 1)) == 0);

    // floor(2^RECIP_SHIFT / COUNTS); quotient error stays below one for SUM_W-bit sums
    localparam int                RECIP_SHIFT = 2 * SUM_W;
    localparam longint unsigned   RECIP       = (64'd1 << RECIP_SHIFT) / ENCODER_COUNTS;
    localparam int                RECIP_W     = $clog2(RECIP + 1);
    localparam int                PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic               mode;
        logic [7:0]         cmd_byte;
        logic [7:0]         temperature;
        logic signed [15:0] current_raw;
        logic signed [15:0] speed_raw;
        logic [15:0]        encoder_raw;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   prev_pos;
        logic [TURNS_W-1:0] turns;
        logic               first_seen;
        logic               heard;
        logic               link;
        logic [7:0]         command;
        logic [7:0]         temp;
        logic signed [15:0] current;
        logic signed [15:0] speed;
    } state_t;

    // (encoder + offset) mod ENCODER_COUNTS
    function automatic logic [POS_W-1:0] pos_reduce(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  quo;
        logic [SUM_W-1:0]  rem;
        if (IS_POW2)
        begin
            rem = sum & SUM_W'(ENCODER_COUNTS - 1);
        end
        else
        begin
            prod = PROD_W'(sum) * PROD_W'(RECIP);
            quo  = SUM_W'(prod >> RECIP_SHIFT);
            rem  = sum - SUM_W'(quo * SUM_W'(ENCODER_COUNTS));
            if (rem >= SUM_W'(ENCODER_COUNTS))
            begin
                rem = rem - SUM_W'(ENCODER_COUNTS);
            end
        end
        return rem[POS_W-1:0];
    endfunction

endpackage

// ===== hdl/mftt_step.sv =====
// Next-state logic of the turn tracker for one item.
// Depends on mftt_pkg (item and state types, pos_reduce).
module mftt_step (
    input  mftt_pkg::item_t     item,
    input  mftt_pkg::state_t    state,
    input  logic [15:0]         offset,
    output mftt_pkg::state_t    state_next,
    output logic                taken
);

    logic [mftt_pkg::POS_W-1:0] pos;
    logic [mftt_pkg::CMP_W-1:0] pos_ext;
    logic [mftt_pkg::CMP_W-1:0] prev_ext;
    logic                       step_up;
    logic                       step_down;

    assign pos      = mftt_pkg::pos_reduce({1'b0, item.encoder_raw} + {1'b0, offset});
    assign pos_ext  = mftt_pkg::CMP_W'(pos);
    assign prev_ext = mftt_pkg::CMP_W'(state.prev_pos);

    // wrap forward: pos - prev < -half; wrap backward: pos - prev > half
    assign step_up   = prev_ext > pos_ext + mftt_pkg::CMP_W'(mftt_pkg::HALF_COUNTS);
    assign step_down = pos_ext > prev_ext + mftt_pkg::CMP_W'(mftt_pkg::HALF_COUNTS);

    always_comb
    begin
        state_next = state;
        taken      = 1'b0;
        if (item.mode == mftt_pkg::MODE_TICK)
        begin
            state_next.link  = state.heard;
            state_next.heard = 1'b0;
        end
        else if (item.temperature != 8'd0)
        begin
            taken = 1'b1;
            if (state.first_seen && step_up)
            begin
                state_next.turns = state.turns + 32'd1;
            end
            else if (state.first_seen && step_down)
            begin
                state_next.turns = state.turns - 32'd1;
            end
            state_next.prev_pos   = pos;
            state_next.first_seen = 1'b1;
            state_next.heard      = 1'b1;
            state_next.command    = item.cmd_byte;
            state_next.temp       = item.temperature;
            state_next.current    = item.current_raw;
            state_next.speed      = item.speed_raw;
        end
    end

endmodule

// ===== hdl/motor_feedback_turn_tracker.sv =====
// Motor feedback turn tracker, top level.
// The result is registered: it is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while no result is held or m_tready is high;
// the position, turn and link state registers update from mftt_step on each accept.
// Reset (rst_n low, asynchronous) clears all tracking state, the offset
// register and the result valid; no clearing pass.
// Depends on mftt_pkg and mftt_step.
module motor_feedback_turn_tracker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,      // encoder offset
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,        // cmd_byte, temperature, current_raw, speed_raw,
                                          // encoder_raw
    input  logic          s_tuser,        // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [151:0]  m_tdata,        // command, temp_out, current_out, speed_out,
                                          // angle_counts, turns, total_position, link_up
    output logic          m_tuser         // frame_taken
);

    mftt_pkg::item_t  item;
    mftt_pkg::state_t state_reg;
    mftt_pkg::state_t state_next;
    mftt_pkg::state_t res_reg;
    logic             taken_next;
    logic             res_taken_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      offset_reg;
    logic             s_fire;

    logic [mftt_pkg::ANGLE_W-1:0] angle;
    logic [mftt_pkg::TOTAL_W-1:0] turns_ext;
    logic [mftt_pkg::TOTAL_W-1:0] total;

    assign item.mode        = s_tuser;
    assign item.cmd_byte    = s_tdata[7:0];
    assign item.temperature = s_tdata[15:8];
    assign item.current_raw = s_tdata[31:16];
    assign item.speed_raw   = s_tdata[47:32];
    assign item.encoder_raw = s_tdata[63:48];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    mftt_step u_step (
        .item       (item),
        .state      (state_reg),
        .offset     (offset_reg),
        .state_next (state_next),
        .taken      (taken_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                offset_reg <= cfg_wdata;
            end
            if (s_fire)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            res_reg       <= state_next;
            res_taken_reg <= taken_next;
        end
    end

    // angle in (-half, half]
    always_comb
    begin
        if ({1'b0, res_reg.prev_pos, 1'b0} > 18'(mftt_pkg::ENCODER_COUNTS))
        begin
            angle = {1'b0, res_reg.prev_pos} - mftt_pkg::ANGLE_W'(mftt_pkg::ENCODER_COUNTS);
        end
        else
        begin
            angle = {1'b0, res_reg.prev_pos};
        end
    end

    assign turns_ext = {{(mftt_pkg::TOTAL_W - mftt_pkg::TURNS_W){res_reg.turns[31]}},
                        res_reg.turns};
    assign total     = mftt_pkg::TOTAL_W'(turns_ext * mftt_pkg::TOTAL_W'(mftt_pkg::ENCODER_COUNTS))
                     + mftt_pkg::TOTAL_W'(res_reg.prev_pos);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_taken_reg;
    assign m_tdata  = {6'd0, res_reg.link, total, res_reg.turns, angle,
                       res_reg.speed, res_reg.current, res_reg.temp, res_reg.command};

    a_tick_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_tuser == mftt_pkg::MODE_TICK)) |=> !res_taken_reg)
        else $error("tick reported as taken frame");

    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg.turns == $past(state_reg.turns)
                 || state_reg.turns == $past(state_reg.turns) + 32'd1
                 || state_reg.turns == $past(state_reg.turns) - 32'd1))
        else $error("turn counter moved by more than one");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |=> $stable(state_reg))
        else $error("state changed without an accepted item");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (res_reg == state_reg))
        else $error("result snapshot differs from tracking state");

endmodule

// ===== verif/turn_tracker_checker.sv =====
// Checker for the motor feedback turn tracker: follows the config port and both
// streams, predicts every result item and compares it field by field.
// Depends on mftt_pkg (item type and encoder count constants).
module turn_tracker_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [151:0] m_tdata,
    input  logic         m_tuser,
    output int           mismatches,
    output int           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               frame_taken;
        logic [7:0]         command;
        logic [7:0]         temp;
        logic signed [15:0] current;
        logic signed [15:0] speed;
        logic signed [16:0] angle;
        logic signed [31:0] turns;
        logic signed [47:0] total;
        logic               link_up;
    } feedback_report_t;

    // tracker state as the block should hold it
    logic [15:0] offset_reg   = '0;
    logic [15:0] last_pos     = '0;
    logic [31:0] turn_count   = '0;
    logic        seen_frame   = 1'b0;
    logic        heard_frame  = 1'b0;
    logic        link_alive   = 1'b0;
    logic [7:0]  cmd_hold     = '0;
    logic [7:0]  temp_hold    = '0;
    logic [15:0] cur_hold     = '0;
    logic [15:0] spd_hold     = '0;

    feedback_report_t  expected_reports[$];
    feedback_report_t  want;
    feedback_report_t  got;
    mftt_pkg::item_t   taken_item;
    int                errors = 0;

    function automatic feedback_report_t track_feedback(mftt_pkg::item_t it);
        int unsigned      pos;
        int               delta;
        longint           wide_turns;
        feedback_report_t r;
        r.frame_taken = 1'b0;
        if (it.mode == mftt_pkg::MODE_TICK)
        begin
            link_alive  = heard_frame;
            heard_frame = 1'b0;
        end
        else if (it.temperature != 8'd0)
        begin
            pos = (32'(it.encoder_raw) + 32'(offset_reg)) % mftt_pkg::ENCODER_COUNTS;
            if (seen_frame)
            begin
                delta = int'(pos) - int'(32'(last_pos));
                if (delta < -int'(mftt_pkg::HALF_COUNTS))
                    turn_count = turn_count + 32'd1;
                else if (delta > int'(mftt_pkg::HALF_COUNTS))
                    turn_count = turn_count - 32'd1;
            end
            last_pos      = pos[15:0];
            seen_frame    = 1'b1;
            heard_frame   = 1'b1;
            cmd_hold      = it.cmd_byte;
            temp_hold     = it.temperature;
            cur_hold      = it.current_raw;
            spd_hold      = it.speed_raw;
            r.frame_taken = 1'b1;
        end
        if (2 * int'(32'(last_pos)) > int'(mftt_pkg::ENCODER_COUNTS))
            r.angle = 17'(int'(32'(last_pos)) - int'(mftt_pkg::ENCODER_COUNTS));
        else
            r.angle = 17'(last_pos);
        wide_turns = longint'(signed'(turn_count));
        r.total    = 48'(wide_turns * longint'(mftt_pkg::ENCODER_COUNTS)
                         + longint'(32'(last_pos)));
        r.command  = cmd_hold;
        r.temp     = temp_hold;
        r.current  = cur_hold;
        r.speed    = spd_hold;
        r.turns    = turn_count;
        r.link_up  = link_alive;
        return r;
    endfunction

    task automatic flag_field(input string fname, input logic signed [63:0] exp_val,
                              input logic signed [63:0] act_val);
        $display("%0t ns: %s mismatch, expected %0d actual %0d",
                 $time, fname, exp_val, act_val);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.frame_taken = m_tuser;
                got.command     = m_tdata[7:0];
                got.temp        = m_tdata[15:8];
                got.current     = m_tdata[31:16];
                got.speed       = m_tdata[47:32];
                got.angle       = m_tdata[64:48];
                got.turns       = m_tdata[96:65];
                got.total       = m_tdata[144:97];
                got.link_up     = m_tdata[145];
                if (expected_reports.size() == 0)
                begin
                    $display("%0t ns: unexpected result item, expected none actual %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.frame_taken !== want.frame_taken)
                        flag_field("frame_taken", want.frame_taken, got.frame_taken);
                    if (got.command !== want.command)
                        flag_field("command", want.command, got.command);
                    if (got.temp !== want.temp)
                        flag_field("temp_out", want.temp, got.temp);
                    if (got.current !== want.current)
                        flag_field("current_out", want.current, got.current);
                    if (got.speed !== want.speed)
                        flag_field("speed_out", want.speed, got.speed);
                    if (got.angle !== want.angle)
                        flag_field("angle_counts", want.angle, got.angle);
                    if (got.turns !== want.turns)
                        flag_field("turns", want.turns, got.turns);
                    if (got.total !== want.total)
                        flag_field("total_position", want.total, got.total);
                    if (got.link_up !== want.link_up)
                        flag_field("link_up", want.link_up, got.link_up);
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken_item = '{mode: s_tuser, cmd_byte: s_tdata[7:0],
                               temperature: s_tdata[15:8], current_raw: s_tdata[31:16],
                               speed_raw: s_tdata[47:32], encoder_raw: s_tdata[63:48]};
                expected_reports.push_back(track_feedback(taken_item));
            end
            // an item taken at the same edge still sees the old offset
            if (cfg_we)
                offset_reg = cfg_wdata;
        end
        outstanding <= expected_reports.size();
        mismatches  <= errors;
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for motor_feedback_turn_tracker: drives frames, ticks and offset
// writes with random idling and stalls, and gives the verdict.
// Depends on mftt_pkg, the tracker RTL and turn_tracker_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CMD_FEEDBACK_A1 = 8'hA1;
    localparam logic [7:0] CMD_FEEDBACK_A6 = 8'hA6;
    localparam int         STUCK_LIMIT     = 5000;
    localparam int         HOLD_CYCLES     = 300;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [151:0] m_tdata;
    logic         m_tuser;

    int           mismatches;
    int           outstanding;
    int           send_idle_pct = 12;
    int           recv_idle_pct = 76;
    logic         hold_kick     = 1'b0;
    int           hold_left     = 0;
    int           stuck_cycles  = 0;
    logic [15:0]  enc_track     = '0;

    always #10 clk = ~clk;

    motor_feedback_turn_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    turn_tracker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_kick)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic push_item(input logic mode, input logic [7:0] cmd, input logic [7:0] temp,
                             input logic [15:0] cur, input logic [15:0] spd,
                             input logic [15:0] enc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {enc, spd, cur, temp, cmd};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic push_frame(input logic [7:0] cmd, input logic [7:0] temp,
                              input logic [15:0] cur, input logic [15:0] spd,
                              input logic [15:0] enc);
        push_item(mftt_pkg::MODE_FRAME, cmd, temp, cur, spd, enc);
    endtask

    task automatic push_tick();
        push_item(mftt_pkg::MODE_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic settle_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_offset(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly a shaft turning in small steps, some jumps around half a turn, some noise
    task automatic random_feedback(input int n);
        int          pick;
        int          step;
        logic [7:0]  cmd;
        logic [7:0]  temp;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                push_tick();
            else
            begin
                if (pick < 72)
                    step = int'($urandom_range(6000)) - 3000;
                else if (pick < 84)
                    step = ($urandom_range(1) ? 1 : -1) * (32767 + int'($urandom_range(2)));
                else
                    step = int'($urandom_range(65535));
                enc_track = enc_track + 16'(step);
                case ($urandom_range(3))
                    0:       cmd = CMD_FEEDBACK_A1;
                    1:       cmd = CMD_FEEDBACK_A6;
                    default: cmd = 8'($urandom);
                endcase
                temp = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
                push_frame(cmd, temp, 16'($urandom), 16'($urandom), enc_track);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty state, first frame, wrap in both directions, half-turn edges
        push_tick();
        push_frame(CMD_FEEDBACK_A1, 8'd0, 16'h1234, 16'h5678, 16'hFFFF);
        push_frame(CMD_FEEDBACK_A1, 8'd255, 16'h8000, 16'h7FFF, 16'hFFFF);
        push_frame(CMD_FEEDBACK_A6, 8'd1, 16'h7FFF, 16'h8000, 16'h0000);
        push_tick();
        push_tick();
        push_frame(8'h00, 8'd40, 16'h0000, 16'hFFFF, 16'h8000);
        push_frame(8'hFF, 8'd41, 16'hFFFF, 16'h0000, 16'h8001);
        push_frame(CMD_FEEDBACK_A1, 8'd42, 16'h0001, 16'h0001, 16'h0000);
        push_frame(CMD_FEEDBACK_A6, 8'd43, 16'h0010, 16'h0020, 16'h8001);
        push_frame(CMD_FEEDBACK_A6, 8'd0, 16'hAAAA, 16'h5555, 16'h1234);
        push_frame(CMD_FEEDBACK_A1, 8'd44, 16'h0100, 16'h0200, 16'h0000);
        push_frame(CMD_FEEDBACK_A1, 8'd45, 16'h0100, 16'h0200, 16'h8000);
        push_tick();
        settle_outputs();
        write_offset(16'hFFFF);
        push_frame(CMD_FEEDBACK_A1, 8'd50, 16'h1111, 16'h2222, 16'hFFFF);
        push_frame(CMD_FEEDBACK_A6, 8'd51, 16'h3333, 16'h4444, 16'h0001);
        push_frame(CMD_FEEDBACK_A6, 8'd52, 16'h5555, 16'h6666, 16'h8000);
        push_tick();
        settle_outputs();
        write_offset(16'h8000);
        push_frame(CMD_FEEDBACK_A1, 8'd60, 16'h0000, 16'h0000, 16'h0000);
        push_frame(CMD_FEEDBACK_A1, 8'd61, 16'h0000, 16'h0000, 16'h7FFF);
        push_frame(CMD_FEEDBACK_A1, 8'd62, 16'h0000, 16'h0000, 16'hFFFF);
        push_tick();
        settle_outputs();

        // sender mostly busy, receiver mostly stalled
        write_offset(16'($urandom));
        send_idle_pct = 12;
        recv_idle_pct = 76;
        random_feedback(200);
        settle_outputs();

        // sender mostly idle, receiver mostly ready
        write_offset(16'h0000);
        send_idle_pct = 76;
        recv_idle_pct = 12;
        random_feedback(100);
        settle_outputs();
        random_feedback(100);
        settle_outputs();

        // no idling; long receiver hold-off while items keep coming
        write_offset(16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_feedback(50);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        random_feedback(100);
        settle_outputs();
        write_offset(16'($urandom));
        random_feedback(100);
        settle_outputs();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
